// File: hw/rtl/gof_pkg.sv
package gof_pkg;

  localparam int GOF_MAX_SEGMENTS = 64;
  localparam int GOF_CFG_IDX_W    = 1;
  localparam int GOF_CFG_DATA_W   = 32;
  localparam int GOF_QUOT_W       = 33;
  localparam int GOF_CNT_W        = 6;

  localparam logic [GOF_CFG_IDX_W-1:0] CFG_SCALE    = 1'b0;
  localparam logic [GOF_CFG_IDX_W-1:0] CFG_SEG_CNT  = 1'b1;

  localparam logic [31:0] SCALE_RESET   = 32'd16777216;
  localparam logic [6:0]  SEG_CNT_RESET = 7'd8;

  localparam logic [1:0] KIND_MOVE  = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_QUAD  = 2'd2;
  localparam logic [1:0] KIND_CUBIC = 2'd3;

  localparam logic [1:0] PT_CURVE = 2'd2;

  // point slots of the Bernstein sum
  localparam logic [1:0] SEL_START = 2'd0;
  localparam logic [1:0] SEL_CTRL  = 2'd1;
  localparam logic [1:0] SEL_CTRL2 = 2'd2;
  localparam logic [1:0] SEL_END   = 2'd3;

  typedef struct packed {
    logic       in_ready;
    logic       load;
    logic       map;
    logic [1:0] sel;
    logic       wgt1;
    logic       wgt2;
    logic       acc;
    logic       div_init;
    logic       div_step;
    logic       emit;
    logic       next_pt;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic curve;
    logic last_pt;
    logic out_free;
  } status_t;

endpackage

// File: hw/rtl/gof_in_if.sv
interface gof_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [15:0] end_x;
  logic signed [15:0] end_y;
  logic signed [15:0] ctrl_x;
  logic signed [15:0] ctrl_y;
  logic signed [15:0] ctrl2_x;
  logic signed [15:0] ctrl2_y;
  logic signed [31:0] pen_x;
  logic signed [31:0] pen_y;

  modport source (output valid, kind, end_x, end_y, ctrl_x, ctrl_y, ctrl2_x, ctrl2_y,
                  pen_x, pen_y, input ready);
  modport sink (input valid, kind, end_x, end_y, ctrl_x, ctrl_y, ctrl2_x, ctrl2_y,
                pen_x, pen_y, output ready);
endinterface

// File: hw/rtl/gof_out_if.sv
interface gof_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         point_kind;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic               last;

  modport source (output valid, point_kind, pos_x, pos_y, last, input ready);
  modport sink (input valid, point_kind, pos_x, pos_y, last, output ready);
endinterface

// File: hw/rtl/gof_ctrl.sv
module gof_ctrl
  import gof_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_MAP  = 8'b00000010,
    S_WGT1 = 8'b00000100,
    S_WGT2 = 8'b00001000,
    S_ACC  = 8'b00010000,
    S_DIVI = 8'b00100000,
    S_DIV  = 8'b01000000,
    S_EMIT = 8'b10000000
  } state_t;

  state_t               state, state_next;
  logic [GOF_CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (st.in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = GOF_CNT_W'(SEL_CTRL);
          state_next = S_MAP;
        end
      end
      S_MAP: begin
        cmd.map = 1'b1;
        cmd.sel = cnt[1:0];
        cnt_next = cnt + 1'b1;
        if (cnt[1:0] == SEL_END) state_next = st.curve ? S_WGT1 : S_EMIT;
      end
      S_WGT1: begin
        cmd.wgt1   = 1'b1;
        state_next = S_WGT2;
      end
      S_WGT2: begin
        cmd.wgt2   = 1'b1;
        cnt_next   = '0;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc  = 1'b1;
        cmd.sel  = cnt[1:0];
        cnt_next = cnt + 1'b1;
        if (cnt[1:0] == SEL_END) state_next = S_DIVI;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == GOF_CNT_W'(GOF_QUOT_W - 1)) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (!st.curve || st.last_pt) begin
            state_next = S_IDLE;
          end else begin
            cmd.next_pt = 1'b1;
            state_next  = S_WGT1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/gof_dp.sv
module gof_dp
  import gof_pkg::*;
#(
  parameter int MAX_SEGMENTS = GOF_MAX_SEGMENTS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [GOF_CFG_IDX_W-1:0]  cfg_index,
  input  logic [GOF_CFG_DATA_W-1:0] cfg_wdata,
  gof_in_if.sink                    item_in,
  gof_out_if.source                 point_out,
  input  cmd_t                      cmd,
  output status_t                   st
);

  localparam int NW = $clog2(MAX_SEGMENTS + 1);
  localparam int DW = 3 * NW;
  localparam int SW = DW + GOF_QUOT_W;
  localparam logic [6:0] MAX_N = 7'(MAX_SEGMENTS);

  // configuration
  logic [31:0] scale;
  logic [6:0]  seg_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale   <= SCALE_RESET;
      seg_cnt <= SEG_CNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCALE:   scale   <= cfg_wdata[31:0];
        CFG_SEG_CNT: seg_cnt <= cfg_wdata[6:0];
        default:     ;
      endcase
    end
  end

  // captured vertex
  logic [1:0]         kind_r;
  logic signed [15:0] gx [1:3];
  logic signed [15:0] gy [1:3];
  logic signed [31:0] pen_x, pen_y;
  logic [NW-1:0]      n_r, i_r;
  logic [2*NW-1:0]    nn_r;
  logic [DW-1:0]      d_r;
  logic signed [31:0] last_x, last_y;
  logic signed [31:0] px [1:3];
  logic signed [31:0] py [1:3];
  logic [NW-1:0]      n_next;

  always_comb begin
    if (seg_cnt == 7'd0) n_next = NW'(1);
    else if (seg_cnt > MAX_N) n_next = NW'(MAX_SEGMENTS);
    else n_next = seg_cnt[NW-1:0];
  end

  // glyph units -> Q16.16: (g*scale + 128) >>> 8, plus pen
  logic [1:0]         msel;
  logic signed [15:0] mgx, mgy;
  logic signed [48:0] prodx, prody;
  logic signed [48:0] rndx, rndy;
  logic signed [31:0] mapx, mapy;

  assign msel  = cmd.sel;
  assign mgx   = (msel == SEL_CTRL) ? gx[1] : (msel == SEL_CTRL2) ? gx[2] : gx[3];
  assign mgy   = (msel == SEL_CTRL) ? gy[1] : (msel == SEL_CTRL2) ? gy[2] : gy[3];
  assign prodx = 49'(mgx) * $signed({1'b0, scale});
  assign prody = 49'(mgy) * $signed({1'b0, scale});
  assign rndx  = prodx + 49'sd128;
  assign rndy  = prody + 49'sd128;
  assign mapx  = rndx[39:8] + pen_x;
  assign mapy  = rndy[39:8] + pen_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      i_r <= NW'(1);
      n_r <= NW'(1);
    end else if (cmd.load) begin
      i_r <= NW'(1);
      n_r <= n_next;
    end else if (cmd.next_pt) begin
      i_r <= i_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= item_in.kind;
      gx[1]  <= item_in.ctrl_x;
      gy[1]  <= item_in.ctrl_y;
      gx[2]  <= item_in.ctrl2_x;
      gy[2]  <= item_in.ctrl2_y;
      gx[3]  <= item_in.end_x;
      gy[3]  <= item_in.end_y;
      pen_x  <= item_in.pen_x;
      pen_y  <= item_in.pen_y;
    end
    if (cmd.map) begin
      case (msel)
        SEL_CTRL:  begin px[1] <= mapx; py[1] <= mapy; nn_r <= n_r * n_r; end
        SEL_CTRL2: begin
          px[2] <= mapx;
          py[2] <= mapy;
          d_r   <= (kind_r == KIND_CUBIC) ? DW'(nn_r) * DW'(n_r) : DW'(nn_r);
        end
        SEL_END:   begin px[3] <= mapx; py[3] <= mapy; end
        default:   ;
      endcase
    end
  end

  // Bernstein weights, quadratic uses slots start, ctrl, end
  logic [NW-1:0]   u;
  logic [2*NW-1:0] uu, ui, ii;
  logic [DW-1:0]   w [0:3];

  assign u = n_r - i_r;

  always_ff @(posedge clk) begin
    if (cmd.wgt1) begin
      uu <= u * u;
      ui <= u * i_r;
      ii <= i_r * i_r;
    end
    if (cmd.wgt2) begin
      if (kind_r == KIND_CUBIC) begin
        w[0] <= DW'(uu) * DW'(u);
        w[1] <= DW'(3 * uu * i_r);
        w[2] <= DW'(3 * ii * u);
        w[3] <= DW'(ii) * DW'(i_r);
      end else begin
        w[0] <= DW'(uu);
        w[1] <= DW'({ui, 1'b0});
        w[2] <= '0;
        w[3] <= DW'(ii);
      end
    end
  end

  // multiply-accumulate, one term per cycle
  logic signed [SW-1:0] accx, accy;
  logic signed [31:0]   apx, apy;
  logic [DW-1:0]        aw;

  assign aw  = w[cmd.sel];
  assign apx = (cmd.sel == SEL_START) ? last_x : px[cmd.sel];
  assign apy = (cmd.sel == SEL_START) ? last_y : py[cmd.sel];

  always_ff @(posedge clk) begin
    if (cmd.wgt2) begin
      accx <= '0;
      accy <= '0;
    end else if (cmd.acc) begin
      accx <= accx + SW'($signed({1'b0, aw})) * SW'(apx);
      accy <= accy + SW'($signed({1'b0, aw})) * SW'(apy);
    end
  end

  // floor((acc + d/2) / d), biased by d*2^31 so the dividend is non-negative
  logic [SW-1:0]         bias, numx, numy;
  logic [DW-1:0]         remx, remy;
  logic [GOF_QUOT_W-1:0] qx, qy;
  logic [DW:0]           tx, ty;

  assign bias = SW'(d_r >> 1) + (SW'(d_r) << 31);
  assign numx = accx + bias;
  assign numy = accy + bias;
  assign tx   = {remx, qx[GOF_QUOT_W-1]};
  assign ty   = {remy, qy[GOF_QUOT_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      remx <= numx[SW-1:GOF_QUOT_W];
      remy <= numy[SW-1:GOF_QUOT_W];
      qx   <= numx[GOF_QUOT_W-1:0];
      qy   <= numy[GOF_QUOT_W-1:0];
    end else if (cmd.div_step) begin
      if (tx >= {1'b0, d_r}) begin
        remx <= DW'(tx - {1'b0, d_r});
        qx   <= {qx[GOF_QUOT_W-2:0], 1'b1};
      end else begin
        remx <= tx[DW-1:0];
        qx   <= {qx[GOF_QUOT_W-2:0], 1'b0};
      end
      if (ty >= {1'b0, d_r}) begin
        remy <= DW'(ty - {1'b0, d_r});
        qy   <= {qy[GOF_QUOT_W-2:0], 1'b1};
      end else begin
        remy <= ty[DW-1:0];
        qy   <= {qy[GOF_QUOT_W-2:0], 1'b0};
      end
    end
  end

  // output register and kept last point
  logic curve, final_pt;

  assign curve    = (kind_r == KIND_QUAD) || (kind_r == KIND_CUBIC);
  assign final_pt = !curve || (i_r == n_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      point_out.valid <= 1'b0;
      last_x          <= '0;
      last_y          <= '0;
    end else begin
      if (cmd.emit) point_out.valid <= 1'b1;
      else if (point_out.ready) point_out.valid <= 1'b0;
      if (cmd.emit && final_pt) begin
        last_x <= px[3];
        last_y <= py[3];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      point_out.last <= final_pt;
      if (curve) begin
        point_out.point_kind <= PT_CURVE;
        point_out.pos_x      <= {~qx[31], qx[30:0]};
        point_out.pos_y      <= {~qy[31], qy[30:0]};
      end else begin
        point_out.point_kind <= kind_r;
        point_out.pos_x      <= px[3];
        point_out.pos_y      <= py[3];
      end
    end
  end

  assign item_in.ready = cmd.in_ready;
  assign st.in_valid   = item_in.valid;
  assign st.curve      = curve;
  assign st.last_pt    = i_r == n_r;
  assign st.out_free   = !point_out.valid || point_out.ready;

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (i_r <= n_r) && (i_r != '0))
    else $error("point index out of range");
  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (remx < d_r) && (remy < d_r))
    else $error("division remainder not below divisor");
  a_last_kept: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && final_pt |=> (last_x == $past(px[3])) && (last_y == $past(py[3])))
    else $error("end point not kept after final point");
`endif

endmodule

// File: hw/rtl/glyph_outline_flattener.sv
// Move and line vertices: load, mapping of both controls and the end point, then emit
// into the output register. Curve vertices: the same mapping, then n points, n being
// segment_count clamped to 1..MAX_SEGMENTS; per point two weight steps, four MAC
// steps, a bias step, 33-step radix-2 divider, emit step; a held output adds its wait.
// One vertex at a time; the next transfer is taken once the last point is registered.
// Synchronous active-high reset: scale 1.0, 8 segments, kept point (0,0), output empty.
module glyph_outline_flattener
  import gof_pkg::*;
#(
  parameter int MAX_SEGMENTS = GOF_MAX_SEGMENTS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [GOF_CFG_IDX_W-1:0]  cfg_index,
  input  logic [GOF_CFG_DATA_W-1:0] cfg_wdata,
  gof_in_if.sink                    item_in,
  gof_out_if.source                 point_out
);

  cmd_t    cmd;
  status_t st;

  gof_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  gof_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .item_in   (item_in),
    .point_out (point_out),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import gof_pkg::*;

  typedef struct {
    logic [1:0]         kind;
    logic signed [15:0] ex, ey, cx, cy, c2x, c2y;
    logic signed [31:0] px, py;
  } vertex_t;

  typedef struct {
    logic [1:0]         kind;
    logic signed [31:0] x, y;
    logic               last;
  } point_t;

  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [GOF_CFG_IDX_W-1:0]  cfg_index = CFG_SCALE;
  logic [GOF_CFG_DATA_W-1:0] cfg_wdata = '0;

  gof_in_if  in_ch();
  gof_out_if out_ch();

  glyph_outline_flattener uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .item_in(in_ch), .point_out(out_ch)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [31:0]        mdl_scale;
  logic [6:0]         mdl_segs;
  logic signed [31:0] pen_last_x, pen_last_y;

  point_t points_due[$];
  int     err_cnt = 0;
  int     idle_cycles = 0;
  bit     stall_req = 0;
  int     stall_left = 0;
  int     out_hold = 0;
  bit     in_burst = 0;

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic longint div_round(input longint a, input longint d);
    longint s, q;
    s = a + d / 2;
    q = s / d;
    if ((s % d) != 0 && s < 0) q--;
    return q;
  endfunction

  function automatic logic signed [31:0] map_glyph(input logic signed [15:0] g,
                                                   input logic signed [31:0] pen);
    longint p;
    p = longint'(g) * longint'({32'b0, mdl_scale});
    p = ((p + 128) >>> 8) + longint'(pen);
    return p[31:0];
  endfunction

  task automatic flatten_vertex(input vertex_t v);
    logic signed [31:0] ex, ey, c1x, c1y, c2x, c2y;
    longint n, u, sx, sy, d, w0, w1, w2, w3, rx, ry;
    point_t p;
    ex = map_glyph(v.ex, v.px);
    ey = map_glyph(v.ey, v.py);
    if (v.kind == KIND_MOVE || v.kind == KIND_LINE) begin
      p.kind = v.kind; p.x = ex; p.y = ey; p.last = 1'b1;
      points_due.insert(points_due.size(), p);
    end else begin
      c1x = map_glyph(v.cx, v.px);
      c1y = map_glyph(v.cy, v.py);
      c2x = map_glyph(v.c2x, v.px);
      c2y = map_glyph(v.c2y, v.py);
      n = mdl_segs;
      if (n < 1) n = 1;
      if (n > GOF_MAX_SEGMENTS) n = GOF_MAX_SEGMENTS;
      for (longint i = 1; i <= n; i++) begin
        u = n - i;
        if (v.kind == KIND_QUAD) begin
          w0 = u * u; w1 = 2 * u * i; w2 = i * i; d = n * n;
          sx = w0 * pen_last_x + w1 * c1x + w2 * ex;
          sy = w0 * pen_last_y + w1 * c1y + w2 * ey;
        end else begin
          w0 = u * u * u; w1 = 3 * u * u * i; w2 = 3 * u * i * i; w3 = i * i * i;
          d = n * n * n;
          sx = w0 * pen_last_x + w1 * c1x + w2 * c2x + w3 * ex;
          sy = w0 * pen_last_y + w1 * c1y + w2 * c2y + w3 * ey;
        end
        rx = div_round(sx, d);
        ry = div_round(sy, d);
        p.kind = PT_CURVE; p.x = rx[31:0]; p.y = ry[31:0]; p.last = (i == n);
        points_due.insert(points_due.size(), p);
      end
    end
    pen_last_x = ex;
    pen_last_y = ey;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (in_burst || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // typed: expected point given directly instead of by the predictor
  task automatic send_vertex(input vertex_t v, input bit typed, input point_t tp);
    int g;
    g = pick_gap();
    repeat (g) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.kind = v.kind;
    in_ch.end_x = v.ex;   in_ch.end_y = v.ey;
    in_ch.ctrl_x = v.cx;  in_ch.ctrl_y = v.cy;
    in_ch.ctrl2_x = v.c2x; in_ch.ctrl2_y = v.c2y;
    in_ch.pen_x = v.px;   in_ch.pen_y = v.py;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    if (typed) begin
      points_due.insert(points_due.size(), tp);
      flatten_vertex(v);
      void'(points_due.pop_back());
    end else begin
      flatten_vertex(v);
    end
  endtask

  task automatic write_reg(input logic [GOF_CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_SCALE) mdl_scale = val;
    else mdl_segs = val[6:0];
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (points_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rnd_glyph();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return $signed(16'($urandom_range(0, 40))) - 16'sd20;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [31:0] rnd_pen();
    case ($urandom_range(0, 5))
      0: return 32'sh80000000;
      1: return 32'sh7fffffff;
      2: return 32'sd0;
      3: return ($signed(32'($urandom_range(0, 200))) - 32'sd100) <<< 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic vertex_t rnd_vertex();
    vertex_t v;
    v.kind = 2'($urandom_range(0, 3));
    v.ex = rnd_glyph(); v.ey = rnd_glyph();
    v.cx = rnd_glyph(); v.cy = rnd_glyph();
    v.c2x = rnd_glyph(); v.c2y = rnd_glyph();
    v.px = rnd_pen(); v.py = rnd_pen();
    return v;
  endfunction

  vertex_t dir_v[$];
  bit      dir_typed[$];
  point_t  dir_pt[$];

  task automatic row(input logic [1:0] k, input int ex, ey, cx, cy, c2x, c2y,
                     input logic [31:0] px, py, input bit typed,
                     input logic [31:0] tx, ty);
    vertex_t v;
    point_t p;
    v.kind = k; v.ex = 16'(ex); v.ey = 16'(ey); v.cx = 16'(cx); v.cy = 16'(cy);
    v.c2x = 16'(c2x); v.c2y = 16'(c2y);
    v.px = px; v.py = py;
    p.kind = k; p.x = tx; p.y = ty; p.last = 1'b1;
    dir_v.insert(dir_v.size(), v);
    dir_typed.insert(dir_typed.size(), typed);
    dir_pt.insert(dir_pt.size(), p);
  endtask

  // output side: random backpressure plus one long hold-off on request
  always @(negedge clk) begin
    int r;
    if (rst) begin
      out_ch.ready = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready = 1'b0;
    end else if (stall_req) begin
      stall_req = 0;
      stall_left = HOLD_CYCLES - 1;
      out_ch.ready = 1'b0;
    end else begin
      if (out_hold > 0) begin
        out_hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) out_hold = $urandom_range(1, 3);
        else if (r < 12) out_hold = $urandom_range(10, 40);
      end
      out_ch.ready = (out_hold == 0);
    end
  end

  always @(posedge clk) begin
    point_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (points_due.size() == 0) begin
        report($sformatf("unexpected point kind=%0d x=%h y=%h", out_ch.point_kind,
                         out_ch.pos_x, out_ch.pos_y));
      end else begin
        e = points_due.pop_front();
        if (out_ch.point_kind !== e.kind)
          report($sformatf("point_kind %0d, want %0d", out_ch.point_kind, e.kind));
        if (out_ch.pos_x !== e.x)
          report($sformatf("pos_x %h, want %h", out_ch.pos_x, e.x));
        if (out_ch.pos_y !== e.y)
          report($sformatf("pos_y %h, want %h", out_ch.pos_y, e.y));
        if (out_ch.last !== e.last)
          report($sformatf("last %0d, want %0d", out_ch.last, e.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("** glyph_outline_flattener: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [31:0] ph_scale[$];
    int          ph_segs[$];
    int          ph_items[$];
    point_t      nop;
    int          hold_at;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_MOVE;
    in_ch.end_x = '0; in_ch.end_y = '0; in_ch.ctrl_x = '0; in_ch.ctrl_y = '0;
    in_ch.ctrl2_x = '0; in_ch.ctrl2_y = '0; in_ch.pen_x = '0; in_ch.pen_y = '0;
    mdl_scale = SCALE_RESET;
    mdl_segs = SEG_CNT_RESET;
    pen_last_x = '0;
    pen_last_y = '0;
    nop = '{default: '0};

    // curve from the reset point first
    row(KIND_QUAD, 100, -50, 20, 30, 7, 7, 0, 0, 0, 0, 0);
    row(KIND_MOVE, 1, 2, 0, 0, 0, 0, 0, 0, 1, 32'h00010000, 32'h00020000);
    row(KIND_MOVE, -32768, 32767, 0, 0, 0, 0, 0, 0, 1, 32'h80000000, 32'h7fff0000);
    row(KIND_LINE, 0, 0, 0, 0, 0, 0, 32'h7fffffff, 32'h80000000, 1,
        32'h7fffffff, 32'h80000000);
    row(KIND_LINE, 32767, -1, 5, 5, 5, 5, 1, 1, 1, 32'h7fff0001, 32'hffff0001);
    row(KIND_QUAD, -32768, 32767, 32767, -32768, 0, 0, 0, 0, 0, 0, 0);
    row(KIND_CUBIC, 32767, 32767, -32768, 32767, 32767, -32768, 32'h12345678,
        32'h87654321, 0, 0, 0);
    // ignored controls on move
    row(KIND_MOVE, 32767, 0, -32768, 32767, 1, -1, 32'h7fffffff, 0, 1,
        32'hfffeffff, 32'h00000000);
    row(KIND_QUAD, 10, 10, -10, 20, 32767, -32768, 32'h00008000, 32'hffff8000, 0, 0, 0);
    row(KIND_CUBIC, -5, 3, 1, -1, -32768, 32767, 0, 0, 0, 0, 0);
    row(KIND_LINE, -32768, -32768, 0, 0, 0, 0, 32'h80000000, 32'h80000000, 1,
        32'h00000000, 32'h00000000);
    row(KIND_CUBIC, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < dir_v.size(); i++)
      send_vertex(dir_v[i], dir_typed[i], dir_pt[i]);
    wait_drained();

    ph_scale = '{32'h01000000, 32'h00000000, 32'hffffffff, $urandom, $urandom,
                 32'h00000080, $urandom, $urandom, $urandom, 32'h00800000};
    ph_segs  = '{4, 1, 3, 0, 65, 2, 127, 64, 5, 1};
    ph_items = '{30, 15, 25, 15, 5, 20, 4, 4, 45, 40};
    hold_at = $urandom_range(3, 20);

    for (int ph = 0; ph < ph_scale.size(); ph++) begin
      write_reg(CFG_SCALE, ph_scale[ph]);
      write_reg(CFG_SEG_CNT, 32'(ph_segs[ph]));
      for (int k = 0; k < ph_items[ph]; k++) begin
        if ($urandom_range(0, 9) == 0) in_burst = !in_burst;
        if (ph == 0 && k == hold_at) stall_req = 1;
        send_vertex(rnd_vertex(), 0, nop);
      end
      wait_drained();
    end

    if (err_cnt == 0) begin
      $display("** glyph_outline_flattener: PASSED **");
    end else begin
      $display("** glyph_outline_flattener: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/gof_pkg.sv
hw/rtl/gof_in_if.sv
hw/rtl/gof_out_if.sv
hw/rtl/gof_ctrl.sv
hw/rtl/gof_dp.sv
hw/rtl/glyph_outline_flattener.sv
verif/tb.sv
